/* rtl/pc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pc_pkg
// Shared constants and types for the partition counter.
// ---------------------------------------------------------------------------
package pc_pkg;

    localparam int MAX_TOTAL_DEFAULT = 127;
    localparam int FIELD_W           = 7;
    localparam int COUNT_W           = 32;
    localparam int IN_TDATA_W        = 16;

    typedef struct packed {
        logic                 start;
        logic [FIELD_W-1:0]   total;
        logic [FIELD_W-1:0]   largest;
    } pc_cmd_t;

    typedef struct packed {
        logic                 done;
        logic [COUNT_W-1:0]   count;
    } pc_rsp_t;

endpackage
`default_nettype wire

/* rtl/partition_count.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// partition_count
// Counts the partitions of a total m into positive parts of at most n.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one query per transfer: total m in bits 6:0,
//   largest part n in bits 13:7. Output stream m_axis returns one result per
//   query: the 32-bit count in tdata, the invalid flag in tuser.
//   A query with m = 0, n = 0 or m above MAX_TOTAL is answered with
//   invalid = 1 and count 0. An n above m is taken as m.
//   A valid query sets row entry 0 to 1 and clears entries 1..m, then runs
//   S = n*(m+1) - n*(n+1)/2 read-add-write steps on the row memory, each a
//   read state (read both operands), then a write state (add and write back).
//   One query is in work at a time; s_axis_tready is high only while idle.
//   A finished result sits in the output register; the next query is taken
//   while it waits, and a new result holds until m_axis accepts the old one.
//   Reset empties the output register and returns to idle; the row memory
//   needs no clearing, since every query writes entries 0..m before use.
// ---------------------------------------------------------------------------
module partition_count #(
    parameter int MAX_TOTAL = pc_pkg::MAX_TOTAL_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // total [6:0], largest_part [13:7], zero [15:14]
    input  wire logic [pc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // count [31:0]
    output logic [pc_pkg::COUNT_W-1:0]         m_axis_tdata,
    // invalid [0]
    output logic                               m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [pc_pkg::FIELD_W-1:0] TOTAL_LIMIT = pc_pkg::FIELD_W'(MAX_TOTAL);

    logic [1:0]                  state_reg, state_next;
    logic [pc_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                        res_invalid_reg, res_invalid_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pc_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                        out_invalid_reg, out_invalid_next;

    logic [pc_pkg::FIELD_W-1:0]  in_total;
    logic [pc_pkg::FIELD_W-1:0]  in_largest;
    logic                        in_bad;
    logic                        in_xfer;

    pc_pkg::pc_cmd_t cmd;
    pc_pkg::pc_rsp_t rsp;

    assign in_total   = s_axis_tdata[pc_pkg::FIELD_W-1:0];
    assign in_largest = s_axis_tdata[2*pc_pkg::FIELD_W-1:pc_pkg::FIELD_W];
    assign in_bad     = (in_total == '0) || (in_largest == '0) || (in_total > TOTAL_LIMIT);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign cmd.start   = in_xfer && !in_bad;
    assign cmd.total   = in_total;
    assign cmd.largest = (in_largest > in_total) ? in_total : in_largest;

    pc_core #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        res_count_next   = res_count_reg;
        res_invalid_next = res_invalid_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_count_next   = out_count_reg;
        out_invalid_next = out_invalid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_bad)
                    begin
                        res_count_next   = '0;
                        res_invalid_next = 1'b1;
                        state_next       = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                if (rsp.done)
                begin
                    res_count_next   = rsp.count;
                    res_invalid_next = 1'b0;
                    state_next       = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_count_next   = res_count_reg;
                    out_invalid_next = res_invalid_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_count_reg   <= res_count_next;
        res_invalid_reg <= res_invalid_next;
        out_count_reg   <= out_count_next;
        out_invalid_reg <= out_invalid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_invalid_reg;

endmodule
`default_nettype wire

/* rtl/pc_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pc_core
// Row memory and fill sequencer: sets row[0] to 1 and clears row[1..m], then
// for each part size k adds row[j-k] into row[j] for j = k..m via READ, WRITE.
// ---------------------------------------------------------------------------
module pc_core #(
    parameter int MAX_TOTAL = pc_pkg::MAX_TOTAL_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pc_pkg::pc_cmd_t cmd,
    output pc_pkg::pc_rsp_t      rsp
);

    localparam int ROW_DEPTH = MAX_TOTAL + 1;
    localparam int AW        = $clog2(ROW_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [pc_pkg::COUNT_W-1:0] row_mem [ROW_DEPTH];
    logic [pc_pkg::COUNT_W-1:0] rd_cur;
    logic [pc_pkg::COUNT_W-1:0] rd_back;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;

    logic                       we;
    logic [AW-1:0]              waddr;
    logic [pc_pkg::COUNT_W-1:0] wdata;
    logic [pc_pkg::COUNT_W-1:0] sum;

    assign sum = rd_cur + rd_back;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        we         = 1'b0;
        waddr      = j_reg;
        wdata      = '0;
        rsp.done   = 1'b0;
        rsp.count  = sum;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    m_next     = cmd.total[AW-1:0];
                    n_next     = cmd.largest[AW-1:0];
                    j_next     = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                we    = 1'b1;
                wdata = (j_reg == '0) ? pc_pkg::COUNT_W'(1) : '0;
                if (j_reg == m_reg)
                begin
                    k_next     = AW'(1);
                    j_next     = AW'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                we    = 1'b1;
                wdata = sum;
                if (j_reg == m_reg)
                begin
                    if (k_reg == n_reg)
                    begin
                        rsp.done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        j_next     = k_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        rd_cur  <= row_mem[j_reg];
        rd_back <= row_mem[j_reg - k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        n_reg <= n_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

endmodule
`default_nettype wire

/* tb/tb_partition_count.sv */
// ---------------------------------------------------------------------------
// tb_partition_count
// Self-checking bench for the partition counter. Queries of a total and a
// largest part go in over the input stream. Each accepted query is priced by
// a table-fill predictor inside a scoreboard. Results returned on the output
// stream are checked in order against the predicted count and invalid flag.
// Directed corner queries come first, then random queries, under three
// patterns of sender and receiver idling.
// ---------------------------------------------------------------------------
module tb_partition_count;

    localparam int ROW_DEPTH     = 128;
    localparam int MAX_REPORTS   = 10;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int DRAIN_CYCLES  = 50;

    typedef struct {
        logic [pc_pkg::COUNT_W-1:0] count;
        logic                       invalid;
    } partition_result_t;

    class partition_scoreboard;
        partition_result_t pending_results[$];
        int mismatches;
        int queries_seen;
        int rejected_seen;
        int large_seen;
        int results_seen;

        function new();
            mismatches    = 0;
            queries_seen  = 0;
            rejected_seen = 0;
            large_seen    = 0;
            results_seen  = 0;
        endfunction

        function partition_result_t count_partitions(
            logic [pc_pkg::FIELD_W-1:0] total,
            logic [pc_pkg::FIELD_W-1:0] largest);
            logic [pc_pkg::COUNT_W-1:0] ways [0:ROW_DEPTH-1];
            partition_result_t          res;
            int                         m;
            int                         n;
            m = total;
            n = largest;
            res.count   = '0;
            res.invalid = 1'b0;
            if (m == 0 || n == 0 || m > pc_pkg::MAX_TOTAL_DEFAULT)
            begin
                res.invalid = 1'b1;
                return res;
            end
            if (n > m)
                n = m;
            ways[0] = pc_pkg::COUNT_W'(1);
            for (int j = 1; j <= m; j++)
                ways[j] = '0;
            for (int k = 1; k <= n; k++)
                for (int j = k; j <= m; j++)
                    ways[j] = ways[j] + ways[j-k];
            res.count = ways[m];
            return res;
        endfunction

        function void note_query(logic [pc_pkg::FIELD_W-1:0] total,
                                 logic [pc_pkg::FIELD_W-1:0] largest);
            partition_result_t res;
            res = count_partitions(total, largest);
            queries_seen++;
            if (res.invalid)
                rejected_seen++;
            if (total[pc_pkg::FIELD_W-1])
                large_seen++;
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [pc_pkg::COUNT_W-1:0] count, logic invalid);
            partition_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: count=%0d invalid=%0b",
                             $time, count, invalid);
                return;
            end
            want = pending_results.pop_front();
            if (count !== want.count || invalid !== want.invalid)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"[%0t] result %0d mismatch: count exp %0d got %0d, ",
                              "invalid exp %0b got %0b"},
                             $time, results_seen, want.count, count,
                             want.invalid, invalid);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // total [6:0], largest_part [13:7], zero [15:14]
    logic [pc_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // count [31:0]
    logic [pc_pkg::COUNT_W-1:0]    m_axis_tdata;
    // invalid [0]
    logic                          m_axis_tuser;

    int send_idle_pct = 13;
    int recv_idle_pct = 50;

    partition_scoreboard sb = new();

    partition_count dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_query(input logic [pc_pkg::FIELD_W-1:0] total,
                              input logic [pc_pkg::FIELD_W-1:0] largest);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pc_pkg::IN_TDATA_W-2*pc_pkg::FIELD_W){1'b0}}, largest, total};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_query(total, largest);
    endtask

    task automatic send_random_query();
        logic [pc_pkg::FIELD_W-1:0] total;
        logic [pc_pkg::FIELD_W-1:0] largest;
        int                         kind;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // rejected: one field zero, the other anything
            if ($urandom_range(0, 1))
            begin
                total   = '0;
                largest = pc_pkg::FIELD_W'($urandom_range(0, 127));
            end
            else
            begin
                total   = pc_pkg::FIELD_W'($urandom_range(0, 127));
                largest = '0;
            end
        end
        else if (kind < 20)
        begin
            total   = pc_pkg::FIELD_W'($urandom_range(64, 127));
            largest = pc_pkg::FIELD_W'($urandom_range(0, 127));
        end
        else
        begin
            total   = pc_pkg::FIELD_W'($urandom_range(1, 24));
            largest = pc_pkg::FIELD_W'($urandom_range(0, 31));
        end
        send_query(total, largest);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                send_query(7'd1,   7'd1);
                send_query(7'd1,   7'd127);
                send_query(7'd0,   7'd0);
                send_query(7'd0,   7'd5);
                send_query(7'd5,   7'd0);
                send_query(7'd127, 7'd0);
                send_query(7'd0,   7'd127);
                send_query(7'd2,   7'd1);
                send_query(7'd2,   7'd2);
                send_query(7'd3,   7'd2);
                send_query(7'd5,   7'd3);
                send_query(7'd10,  7'd10);
                send_query(7'd10,  7'd127);
                send_query(7'd20,  7'd5);
                send_query(7'd64,  7'd64);
                send_query(7'd127, 7'd1);
                send_query(7'd127, 7'd2);
                send_query(7'd127, 7'd127);
                send_query(7'd126, 7'd127);
                send_query(7'd100, 7'd50);
                send_query(7'd85,  7'd42);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_query();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d queries (%0d rejected, %0d with total of 64 or more),",
                 sb.queries_seen, sb.rejected_seen, sb.large_seen);
        $display("%0d results under three idle patterns; %0d mismatches",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
